// ===== hdl/crpe_pkg.sv =====
// ----------------------------------------------------------------------------
// crpe_pkg: shared types and constants of the clipped raster primitive engine
// command and pixel transaction types, op codes, and the queued work entry
// ----------------------------------------------------------------------------
`default_nettype none

package crpe_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int PIXEL_BITS = 32;
  localparam int DIM_W      = 13;
  localparam int CRD_W      = 18;
  localparam int ADDR_W     = 24;

  localparam logic [2:0] OP_ADVANCE   = 3'd0;
  localparam logic [2:0] OP_PIXEL     = 3'd1;
  localparam logic [2:0] OP_HLINE     = 3'd2;
  localparam logic [2:0] OP_VLINE     = 3'd3;
  localparam logic [2:0] OP_OUTLINE   = 3'd4;
  localparam logic [2:0] OP_FILL_RECT = 3'd5;
  localparam logic [2:0] OP_FILL_SURF = 3'd6;
  localparam logic [2:0] OP_NONE      = 3'd7;

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic [DIM_W-1:0]        dim_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] size_w;
    logic signed [15:0] size_h;
    logic [31:0]        color_word;
  } cmd_item_t;

  typedef struct packed {
    logic [23:0] pixel_address;
    logic [31:0] pixel_value;
    logic        last_pixel;
  } pix_item_t;

  // effective surface size, clamped
  typedef struct packed {
    dim_t width;
    dim_t height;
  } surf_t;

  // unclipped bounds of a primitive, half-open, plus the edge offsets
  typedef struct packed {
    crd_t x_lo;
    crd_t x_lo_p1;
    crd_t x_hi_m1;
    crd_t x_hi;
    crd_t y_lo;
    crd_t y_lo_p1;
    crd_t y_hi_m1;
    crd_t y_hi;
  } geom_t;

  typedef struct packed {
    logic                  advance;
    logic [2:0]            mode;
    logic                  size_ok;
    logic [PIXEL_BITS-1:0] color;
    geom_t                 geom;
  } work_t;

endpackage

`default_nettype wire

// ===== hdl/clipped_raster_primitive_engine.sv =====
// ----------------------------------------------------------------------------
// clipped_raster_primitive_engine: 2d rectangle fill and line blitter
// clips draw commands to the surface and walks them out as framebuffer writes
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  content
//  cmd       in         cmd_valid / cmd_ready      op, position, size, colour
//  pix       out        pix_valid / pix_ready      address, value, last flag
//  apb       in         psel / penable / pready    surface width and height
//
// one transaction per cycle on cmd and one framebuffer write per cycle on pix
// unless stalled; an advance's write passes a queue slot, then the output register
// the walk forms row times width plus column and the cursor step combinationally
// rst is synchronous; it empties the queue, drops any walk and any pending write
// cmd stalls only when the work queue is full; pix backpressure holds the
// output register and stops the walk without dropping anything
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_raster_primitive_engine #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  // command transactions
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  crpe_pkg::cmd_item_t  cmd_item,
  // framebuffer write transactions
  output logic                 pix_valid,
  input  logic                 pix_ready,
  output crpe_pkg::pix_item_t  pix_item,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import crpe_pkg::*;

  // register index, taken from the word address bit
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam dim_t WIDTH_RESET  = dim_t'(640);
  localparam dim_t HEIGHT_RESET = dim_t'(480);

  // configuration registers, raw as written
  dim_t  width_reg;
  dim_t  height_reg;
  surf_t surf;
  logic  reg_write;

  // decode to queue
  logic  q_push;
  work_t q_work_in;
  logic  q_full;

  // queue to walk
  logic  q_pop;
  logic  q_valid;
  work_t q_work_out;

  function automatic dim_t clamp_dim(dim_t r);
    return (r > dim_t'(MAX_DIM)) ? dim_t'(MAX_DIM) : r;
  endfunction

  // ------------------------------------------------------------------------
  // register port: pready held high, written on the access phase
  // ------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (reg_write) begin
      unique case (paddr[2])
        REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = 32'(width_reg);
      REG_HEIGHT: prdata = 32'(height_reg);
      default:    prdata = '0;
    endcase
  end

  // the walk sees the clamped size; the raw value stays readable
  assign surf.width  = clamp_dim(width_reg);
  assign surf.height = clamp_dim(height_reg);

  // ------------------------------------------------------------------------
  // front: decode and bound forming, no state of its own
  // ------------------------------------------------------------------------
  crpe_front u_front (
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_work    (q_work_in)
  );

  // ------------------------------------------------------------------------
  // queue: lets decode run ahead while the walk waits on pix_ready
  // ------------------------------------------------------------------------
  crpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_work_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_work_out)
  );

  // ------------------------------------------------------------------------
  // back: clip, walk and emit; unless pix stalls, one queue entry per cycle
  // ------------------------------------------------------------------------
  crpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_work    (q_work_out),
    .q_pop     (q_pop),
    .surf      (surf),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_item  (pix_item)
  );

  // ------------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------------

  // a write only appears after the walk took an entry from the queue
  assert property (@(posedge clk) disable iff (rst)
    $rose(pix_valid) |-> $past(q_pop))
    else $error("framebuffer write without a queue entry behind it");

  // a full queue stays full until the walk drains an entry
  assert property (@(posedge clk) disable iff (rst)
    (!cmd_ready && !q_pop) |=> !cmd_ready)
    else $error("queue space appeared without a pop");

  // a pushed entry is visible to the walk on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> q_valid)
    else $error("pushed entry lost in the queue");

  // the walk never pops an empty queue
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== hdl/crpe_front.sv =====
// ----------------------------------------------------------------------------
// crpe_front: command decode
// accepts command transactions, drops meaningless ops, forms the unclipped
// bounds of the primitive and the size check, and pushes the work entry
// ----------------------------------------------------------------------------
`default_nettype none

module crpe_front (
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  crpe_pkg::cmd_item_t  cmd_item,
  input  logic                 q_full,
  output logic                 q_push,
  output crpe_pkg::work_t      q_work
);
  import crpe_pkg::*;

  localparam crd_t CRD_ONE = crd_t'(1);
  localparam crd_t CRD_BIG = {1'b0, {(CRD_W-1){1'b1}}};

  crd_t  x, y, w, h;
  crd_t  x_p1, y_p1, x_end, y_end;
  logic  w_pos, h_pos;
  geom_t g;

  assign cmd_ready = !q_full;
  assign q_push    = cmd_valid && cmd_ready && (cmd_item.op != OP_NONE);

  always_comb begin
    x     = crd_t'(cmd_item.pos_x);
    y     = crd_t'(cmd_item.pos_y);
    w     = crd_t'(cmd_item.size_w);
    h     = crd_t'(cmd_item.size_h);
    x_p1  = x + CRD_ONE;
    y_p1  = y + CRD_ONE;
    x_end = x + w;
    y_end = y + h;
    w_pos = !cmd_item.size_w[15] && (cmd_item.size_w != '0);
    h_pos = !cmd_item.size_h[15] && (cmd_item.size_h != '0);

    g.x_lo    = x;
    g.x_lo_p1 = x_p1;
    g.x_hi_m1 = x + w - CRD_ONE;
    g.x_hi    = x_end;
    g.y_lo    = y;
    g.y_lo_p1 = y_p1;
    g.y_hi_m1 = y + h - CRD_ONE;
    g.y_hi    = y_end;

    q_work.size_ok = 1'b1;
    unique case (cmd_item.op)
      OP_PIXEL: begin
        g.x_hi = x_p1;
        g.y_hi = y_p1;
      end
      OP_HLINE: begin
        g.y_hi         = y_p1;
        q_work.size_ok = w_pos;
      end
      OP_VLINE: begin
        g.x_hi         = x_p1;
        q_work.size_ok = h_pos;
      end
      OP_OUTLINE: begin
        q_work.size_ok = w_pos && h_pos;
      end
      OP_FILL_SURF: begin
        // clipping to the surface trims this to the whole surface
        g.x_lo = '0;
        g.y_lo = '0;
        g.x_hi = CRD_BIG;
        g.y_hi = CRD_BIG;
      end
      default: ;
    endcase

    q_work.advance = (cmd_item.op == OP_ADVANCE);
    q_work.mode    = cmd_item.op;
    q_work.color   = cmd_item.color_word[PIXEL_BITS-1:0];
    q_work.geom    = g;
  end

endmodule

`default_nettype wire

// ===== hdl/crpe_queue.sv =====
// ----------------------------------------------------------------------------
// crpe_queue: work queue between decode and raster walk
// small register fifo with a registered fill level
// ----------------------------------------------------------------------------
`default_nettype none

module crpe_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  crpe_pkg::work_t  push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output crpe_pkg::work_t  pop_data
);
  import crpe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] level;

  function automatic logic [PTR_W-1:0] ptr_step(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (level == CNT_W'(DEPTH));
  assign valid    = (level != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_step(wr_ptr);
      if (pop)  rd_ptr <= ptr_step(rd_ptr);
      if (push && !pop)      level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ===== hdl/crpe_back.sv =====
// ----------------------------------------------------------------------------
// crpe_back: raster walk
// arms a clipped walk on a command taken while idle, emits one framebuffer
// write per advance, steps the outline edges and holds the result in an output register
// ----------------------------------------------------------------------------
`default_nettype none

module crpe_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  crpe_pkg::work_t      q_work,
  output logic                 q_pop,
  input  crpe_pkg::surf_t      surf,
  output logic                 pix_valid,
  input  logic                 pix_ready,
  output crpe_pkg::pix_item_t  pix_item
);
  import crpe_pkg::*;

  localparam logic [1:0] PH_TOP    = 2'd0;
  localparam logic [1:0] PH_BOTTOM = 2'd1;
  localparam logic [1:0] PH_LEFT   = 2'd2;
  localparam logic [1:0] PH_RIGHT  = 2'd3;

  typedef struct packed {
    crd_t x0;
    crd_t x1;
    crd_t y0;
    crd_t y1;
  } box_t;

  typedef struct packed {
    logic nonempty;
    dim_t c0;
    dim_t c1;
    dim_t r0;
    dim_t r1;
  } span_t;

  function automatic box_t edge_box(geom_t g, logic outline, logic [1:0] p);
    box_t b;
    b.x0 = g.x_lo;
    b.x1 = g.x_hi;
    b.y0 = g.y_lo;
    b.y1 = g.y_hi;
    if (outline) begin
      case (p)
        PH_TOP:    b.y1 = g.y_lo_p1;
        PH_BOTTOM: b.y0 = g.y_hi_m1;
        PH_LEFT:   b.x1 = g.x_lo_p1;
        default:   b.x0 = g.x_hi_m1;
      endcase
    end
    return b;
  endfunction

  function automatic span_t clip_box(box_t b, surf_t s);
    crd_t  ws, hs, c0, c1, r0, r1;
    span_t r;
    ws = {{(CRD_W-DIM_W){1'b0}}, s.width};
    hs = {{(CRD_W-DIM_W){1'b0}}, s.height};
    c0 = b.x0[CRD_W-1] ? '0 : b.x0;
    r0 = b.y0[CRD_W-1] ? '0 : b.y0;
    c1 = (b.x1 < ws) ? b.x1 : ws;
    r1 = (b.y1 < hs) ? b.y1 : hs;
    r.nonempty = (c0 < c1) && (r0 < r1);
    r.c0 = c0[DIM_W-1:0];
    r.c1 = c1[DIM_W-1:0];
    r.r0 = r0[DIM_W-1:0];
    r.r1 = r1[DIM_W-1:0];
    return r;
  endfunction

  // walk state
  logic                  busy;
  logic                  outline_mode;
  logic [1:0]            outline_phase;
  dim_t                  cursor_col, cursor_row, col_first, col_limit, row_limit;
  geom_t                 geom;
  logic [PIXEL_BITS-1:0] pen_color;

  logic                  take, load_cmd, emit;
  geom_t                 src_geom;
  logic                  src_outline;
  logic [1:0]            start_phase;
  span_t                 spans [4];
  logic                  found;
  logic [1:0]            sel_phase;
  span_t                 sel_span;
  logic [DIM_W:0]        col_inc, row_inc;
  logic                  col_wrap, row_wrap, next_edge, more;
  logic [2*DIM_W-1:0]    row_base;
  logic [ADDR_W-1:0]     addr;

  assign take     = q_valid && (!pix_valid || pix_ready);
  assign q_pop    = take;
  assign load_cmd = take && !q_work.advance && !busy;
  assign emit     = take && q_work.advance && busy;

  // edge search: on a command from the queue entry, otherwise from the saved primitive
  always_comb begin
    src_geom    = load_cmd ? q_work.geom : geom;
    src_outline = load_cmd ? (q_work.mode == OP_OUTLINE) : outline_mode;
    start_phase = load_cmd ? PH_TOP : outline_phase + 1'b1;
    for (int p = 0; p < 4; p++) begin
      spans[p] = clip_box(edge_box(src_geom, src_outline, 2'(p)), surf);
    end
    found     = 1'b0;
    sel_phase = PH_TOP;
    sel_span  = spans[0];
    for (int p = 3; p >= 0; p--) begin
      if (spans[p].nonempty && (2'(p) >= start_phase)) begin
        found     = 1'b1;
        sel_phase = 2'(p);
        sel_span  = spans[p];
      end
    end
  end

  always_comb begin
    col_inc   = {1'b0, cursor_col} + 1'b1;
    row_inc   = {1'b0, cursor_row} + 1'b1;
    col_wrap  = (col_inc >= {1'b0, col_limit});
    row_wrap  = col_wrap && (row_inc >= {1'b0, row_limit});
    next_edge = row_wrap && outline_mode && (outline_phase != PH_RIGHT);
    more      = !row_wrap || (next_edge && found);
    row_base  = cursor_row * surf.width;
    addr      = ADDR_W'(row_base + (2*DIM_W)'(cursor_col));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (load_cmd)  busy <= q_work.size_ok && found;
      else if (emit) busy <= more;
      if (emit)           pix_valid <= 1'b1;
      else if (pix_ready) pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cmd) begin
      outline_mode  <= (q_work.mode == OP_OUTLINE);
      geom          <= q_work.geom;
      pen_color     <= q_work.color;
      outline_phase <= sel_phase;
      cursor_col    <= sel_span.c0;
      col_first     <= sel_span.c0;
      col_limit     <= sel_span.c1;
      cursor_row    <= sel_span.r0;
      row_limit     <= sel_span.r1;
    end
    if (emit) begin
      pix_item.pixel_address <= addr;
      pix_item.pixel_value   <= 32'(pen_color);
      pix_item.last_pixel    <= !more;
      if (!col_wrap) begin
        cursor_col <= col_inc[DIM_W-1:0];
      end else if (!row_wrap) begin
        cursor_col <= col_first;
        cursor_row <= row_inc[DIM_W-1:0];
      end else if (next_edge && found) begin
        outline_phase <= sel_phase;
        cursor_col    <= sel_span.c0;
        col_first     <= sel_span.c0;
        col_limit     <= sel_span.c1;
        cursor_row    <= sel_span.r0;
        row_limit     <= sel_span.r1;
      end
    end
  end

endmodule

`default_nettype wire
